/* design/gh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gh_pkg;

    // Pipeline depth of the bearing chain, one rotation step per cell
    localparam int CORDIC_STEPS    = 16;
    localparam int COORD_FRAC_BITS = 16;

    // Field and datapath widths
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int AD_W      = 31;
    localparam int SQ_W      = 62;
    localparam int CW        = 36;   // rotation x/y, covers CORDIC gain on 33-bit vectors
    localparam int ACC_W     = 32;   // angle accumulator, 2^32 per turn
    localparam int ANG_W     = 16;
    localparam int COST_W    = 17;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH  = 2'd2;

    localparam logic [AD_W-1:0]   AD_RESET   = AD_W'(1) << (COORD_FRAC_BITS - 1);
    localparam logic [COST_W-1:0] COST_ONE   = 17'h10000;
    localparam logic [ACC_W-1:0]  ACC_HALF   = 32'h8000_0000;
    localparam logic [ACC_W-1:0]  ROUND_HALF = 32'h0000_8000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ACC_W-1:0] ATAN_TAB [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Item state handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ACC_W-1:0]     acc;
        logic [ANG_W-1:0]     heading;
        logic                 bypass;   // cost forced to 1.0
        logic                 zero;     // end point on goal, bearing 0
    } cell_data_t;

endpackage

`default_nettype wire

/* design/gh_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module gh_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic                              has_points,
    input  wire logic signed [gh_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [gh_pkg::COORD_W-1:0] start_y,
    input  wire logic signed [gh_pkg::COORD_W-1:0] end_x,
    input  wire logic signed [gh_pkg::COORD_W-1:0] end_y,
    input  wire logic [gh_pkg::ANG_W-1:0]          end_heading,
    input  wire logic signed [gh_pkg::COORD_W-1:0] goal_x,
    input  wire logic signed [gh_pkg::COORD_W-1:0] goal_y,
    input  wire logic [gh_pkg::AD_W-1:0]           approach_distance,
    output logic                                   out_valid,
    output gh_pkg::cell_data_t                     out_data
);

    // Stage 1: differences
    logic                              s1_valid_reg;
    logic                              s1_hp_reg;
    logic signed [gh_pkg::DIFF_W-1:0]  s1_dx_reg, s1_dy_reg, s1_vx_reg, s1_vy_reg;
    logic [gh_pkg::ANG_W-1:0]          s1_head_reg;
    logic signed [gh_pkg::DIFF_W-1:0]  s1_dx_next, s1_dy_next, s1_vx_next, s1_vy_next;

    assign s1_dx_next = {start_x[gh_pkg::COORD_W-1], start_x} - {goal_x[gh_pkg::COORD_W-1], goal_x};
    assign s1_dy_next = {start_y[gh_pkg::COORD_W-1], start_y} - {goal_y[gh_pkg::COORD_W-1], goal_y};
    assign s1_vx_next = {goal_x[gh_pkg::COORD_W-1], goal_x} - {end_x[gh_pkg::COORD_W-1], end_x};
    assign s1_vy_next = {goal_y[gh_pkg::COORD_W-1], goal_y} - {end_y[gh_pkg::COORD_W-1], end_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_hp_reg   <= has_points;
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_vx_reg   <= s1_vx_next;
            s1_vy_reg   <= s1_vy_next;
            s1_head_reg <= end_heading;
        end
    end

    // Stage 2: squares, range flags, vector pre-rotation into the right half-plane
    logic [gh_pkg::DIFF_W-1:0]     adx, ady;
    logic                          s2_ovf_next;
    logic [gh_pkg::SQ_W-1:0]       s2_sqx_next, s2_sqy_next, s2_ad2_next;
    logic signed [gh_pkg::CW-1:0]  vx_ext, vy_ext, s2_x_next, s2_y_next;
    logic                          neg;

    assign adx = s1_dx_reg[gh_pkg::DIFF_W-1] ? (~s1_dx_reg + 1'b1) : s1_dx_reg;
    assign ady = s1_dy_reg[gh_pkg::DIFF_W-1] ? (~s1_dy_reg + 1'b1) : s1_dy_reg;
    assign s2_ovf_next = (|adx[gh_pkg::DIFF_W-1:gh_pkg::AD_W])
                       | (|ady[gh_pkg::DIFF_W-1:gh_pkg::AD_W]);
    assign s2_sqx_next = adx[gh_pkg::AD_W-1:0] * adx[gh_pkg::AD_W-1:0];
    assign s2_sqy_next = ady[gh_pkg::AD_W-1:0] * ady[gh_pkg::AD_W-1:0];
    assign s2_ad2_next = approach_distance * approach_distance;

    assign vx_ext    = {{(gh_pkg::CW - gh_pkg::DIFF_W){s1_vx_reg[gh_pkg::DIFF_W-1]}}, s1_vx_reg};
    assign vy_ext    = {{(gh_pkg::CW - gh_pkg::DIFF_W){s1_vy_reg[gh_pkg::DIFF_W-1]}}, s1_vy_reg};
    assign neg       = s1_vx_reg[gh_pkg::DIFF_W-1];
    assign s2_x_next = neg ? -vx_ext : vx_ext;
    assign s2_y_next = neg ? -vy_ext : vy_ext;

    logic                          s2_valid_reg;
    logic                          s2_hp_reg, s2_ovf_reg, s2_zero_reg;
    logic [gh_pkg::SQ_W-1:0]       s2_sqx_reg, s2_sqy_reg, s2_ad2_reg;
    logic signed [gh_pkg::CW-1:0]  s2_x_reg, s2_y_reg;
    logic [gh_pkg::ACC_W-1:0]      s2_acc_reg;
    logic [gh_pkg::ANG_W-1:0]      s2_head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_hp_reg   <= s1_hp_reg;
            s2_ovf_reg  <= s2_ovf_next;
            s2_sqx_reg  <= s2_sqx_next;
            s2_sqy_reg  <= s2_sqy_next;
            s2_ad2_reg  <= s2_ad2_next;
            s2_x_reg    <= s2_x_next;
            s2_y_reg    <= s2_y_next;
            s2_acc_reg  <= neg ? gh_pkg::ACC_HALF : '0;
            s2_zero_reg <= (s1_vx_reg == '0) && (s1_vy_reg == '0);
            s2_head_reg <= s1_head_reg;
        end
    end

    // Stage 3: approach radius test on squared distances
    logic               far;
    gh_pkg::cell_data_t s3_data_next;
    gh_pkg::cell_data_t s3_data_reg;
    logic               s3_valid_reg;

    assign far = s2_ovf_reg
              || (({1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg}) >= {1'b0, s2_ad2_reg});

    always_comb
    begin
        s3_data_next.x       = s2_x_reg;
        s3_data_next.y       = s2_y_reg;
        s3_data_next.acc     = s2_acc_reg;
        s3_data_next.heading = s2_head_reg;
        s3_data_next.bypass  = !s2_hp_reg || far;
        s3_data_next.zero    = s2_zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

`default_nettype wire

/* design/gh_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module gh_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic [gh_pkg::STEP_W-1:0] step,
    input  wire logic                      in_valid,
    input  wire gh_pkg::cell_data_t        in_data,
    output logic                           out_valid,
    output gh_pkg::cell_data_t             out_data
);

    logic signed [gh_pkg::CW-1:0] xs, ys;
    logic                         rot_pos;
    gh_pkg::cell_data_t           data_next;
    gh_pkg::cell_data_t           data_reg;
    logic                         valid_reg;

    // One vectoring step: drive y toward zero, both updates from old x/y
    assign xs      = $signed(in_data.x) >>> step;
    assign ys      = $signed(in_data.y) >>> step;
    assign rot_pos = !in_data.y[gh_pkg::CW-1] && (in_data.y != '0);

    always_comb
    begin
        data_next = in_data;
        if (rot_pos)
        begin
            data_next.x   = in_data.x + ys;
            data_next.y   = in_data.y - xs;
            data_next.acc = in_data.acc + gh_pkg::ATAN_TAB[step];
        end
        else
        begin
            data_next.x   = in_data.x - ys;
            data_next.y   = in_data.y + xs;
            data_next.acc = in_data.acc - gh_pkg::ATAN_TAB[step];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* design/gh_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module gh_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire gh_pkg::cell_data_t     in_data,
    output logic                        out_valid,
    output logic [gh_pkg::COST_W-1:0]   cost
);

    logic [gh_pkg::ACC_W-1:0]  acc_round;
    logic [gh_pkg::ANG_W-1:0]  bearing, diff, absd;
    logic [gh_pkg::COST_W-1:0] cost_next;
    logic [gh_pkg::COST_W-1:0] cost_reg;
    logic                      valid_reg;

    // Round accumulator to a 16-bit bearing, wrap error, take magnitude
    assign acc_round = in_data.acc + gh_pkg::ROUND_HALF;
    assign bearing   = in_data.zero ? '0 : acc_round[gh_pkg::ACC_W-1 -: gh_pkg::ANG_W];
    assign diff      = in_data.heading - bearing;
    assign absd      = diff[gh_pkg::ANG_W-1] ? (~diff + 1'b1) : diff;
    assign cost_next = in_data.bypass ? gh_pkg::COST_ONE : {absd, 1'b0};

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cost_reg <= cost_next;
        end
    end

    assign out_valid = valid_reg;
    assign cost      = cost_reg;

endmodule

`default_nettype wire

/* design/goal_heading_cost.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// item      item_valid/item_stall   has_points, start_x, start_y, end_x, end_y, end_heading
// cost      cost_valid/cost_stall   cost
// config    cfg_write               cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; registers in order:
// difference stage, square stage, radius compare, one cell per rotation step, output register.
// The whole pipeline advances together; it holds, and item_stall rises, only while
// a finished cost waits under cost_stall.
// rst_n clears all valid bits and loads the register reset values.
module goal_heading_cost (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [gh_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gh_pkg::COORD_W-1:0]          cfg_data,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic                                has_points,
    input  wire logic signed [gh_pkg::COORD_W-1:0]   start_x,
    input  wire logic signed [gh_pkg::COORD_W-1:0]   start_y,
    input  wire logic signed [gh_pkg::COORD_W-1:0]   end_x,
    input  wire logic signed [gh_pkg::COORD_W-1:0]   end_y,
    input  wire logic [gh_pkg::ANG_W-1:0]            end_heading,
    output logic                                     cost_valid,
    input  wire logic                                cost_stall,
    output logic [gh_pkg::COST_W-1:0]                cost
);

    // Configuration registers
    logic signed [gh_pkg::COORD_W-1:0] goal_x_reg, goal_y_reg;
    logic [gh_pkg::AD_W-1:0]           ad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            ad_reg     <= gh_pkg::AD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gh_pkg::CFG_GOAL_X:   goal_x_reg <= cfg_data;
                gh_pkg::CFG_GOAL_Y:   goal_y_reg <= cfg_data;
                gh_pkg::CFG_APPROACH: ad_reg     <= cfg_data[gh_pkg::AD_W-1:0];
                default:              ;
            endcase
        end
    end

    // Global advance: hold only when the output item is stalled
    logic en;
    assign en         = !(cost_valid && cost_stall);
    assign item_stall = !en;

    logic               chain_valid [0:gh_pkg::CORDIC_STEPS];
    gh_pkg::cell_data_t chain_data  [0:gh_pkg::CORDIC_STEPS];

    gh_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (item_valid),
        .has_points        (has_points),
        .start_x           (start_x),
        .start_y           (start_y),
        .end_x             (end_x),
        .end_y             (end_y),
        .end_heading       (end_heading),
        .goal_x            (goal_x_reg),
        .goal_y            (goal_y_reg),
        .approach_distance (ad_reg),
        .out_valid         (chain_valid[0]),
        .out_data          (chain_data[0])
    );

    // Row of rotation cells
    for (genvar i = 0; i < gh_pkg::CORDIC_STEPS; i++)
    begin : g_cell
        gh_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (gh_pkg::STEP_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    gh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[gh_pkg::CORDIC_STEPS]),
        .in_data   (chain_data[gh_pkg::CORDIC_STEPS]),
        .out_valid (cost_valid),
        .cost      (cost)
    );

    // Assertions
    a_cost_range: assert property (@(posedge clk) disable iff (!rst_n)
        cost_valid |-> (cost <= gh_pkg::COST_ONE))
        else $error("cost above 1.0");

    a_cost_even: assert property (@(posedge clk) disable iff (!rst_n)
        cost_valid |-> !cost[0])
        else $error("cost lsb set");

    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cost_valid && cost_stall) |-> item_stall)
        else $error("item taken while output held");

    a_free_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !cost_valid |-> !item_stall)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire

/* sim/goal_heading_cost_tb.sv */
`timescale 1ns / 1ps

module goal_heading_cost_tb;

    // Unused register index: writes to it must be dropped
    localparam logic [gh_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [16:0] FULL_COST     = 17'h10000;
    localparam logic [30:0] RADIUS_AT_RST = 31'h0000_8000;   // 0.5 m
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          DRAIN_CYCLES  = 30;
    localparam int          RANDOM_ITEMS  = 700;
    localparam int          MAX_REPORTS   = 10;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] TURN_ATAN [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

    // One trajectory item
    typedef struct packed {
        logic        hp;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [15:0] hd;
    } traj_t;

    // Directed row: an item, or a register write with its data in sx
    typedef struct packed {
        row_kind_e                     kind;
        logic [gh_pkg::CFG_IDX_W-1:0]  reg_index;
        logic                          hp;
        logic [31:0]                   sx;
        logic [31:0]                   sy;
        logic [31:0]                   ex;
        logic [31:0]                   ey;
        logic [15:0]                   hd;
        logic                          fixed;
        logic [16:0]                   cost;
    } dir_row_t;

    // Cost known up front for a directed item, else taken from the predictor
    typedef struct packed {
        logic        fixed;
        logic [16:0] value;
    } preset_t;

    localparam int NUM_ROWS = 22;
    localparam dir_row_t DIRECTED [NUM_ROWS] = '{
        // empty trajectory, all other fields ones
        '{ROW_ITEM, REG_SPARE, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF,
          32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 17'h10000},
        // end on goal, heading matches
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00000000, 32'h00000000,
          32'h00000000, 32'h00000000, 16'h0000, 1'b1, 17'h00000},
        // end on goal, error of a half turn
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00000000, 32'h00000000,
          32'h00000000, 32'h00000000, 16'h8000, 1'b1, 17'h10000},
        // end on goal, error of one step below zero
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00000000, 32'h00000000,
          32'h00000000, 32'h00000000, 16'hFFFF, 1'b1, 17'h00002},
        // start exactly on the radius
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00008000, 32'h00000000,
          32'h00000000, 32'h00000000, 16'h1234, 1'b1, 17'h10000},
        // start just inside the radius, quarter turn error
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00007FFF, 32'h00000000,
          32'h00000000, 32'h00000000, 16'h4000, 1'b1, 17'h08000},
        // negative start inside radius, end at most negative corner
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'hFFFFA57E, 32'hFFFFA57E,
          32'h80000000, 32'h80000000, 16'h1234, 1'b0, 17'h00000},
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00000000, 32'h00000000,
          32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0, 17'h00000},
        // bearing along the axes
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00000000, 32'h00000000,
          32'hFFFF0000, 32'h00000000, 16'h0000, 1'b0, 17'h00000},
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00000000, 32'h00000000,
          32'h00010000, 32'h00000000, 16'h8000, 1'b0, 17'h00000},
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00000000, 32'h00000000,
          32'h00000000, 32'h00010000, 16'h4000, 1'b0, 17'h00000},
        // start at field extremes, far away
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h80000000, 32'h7FFFFFFF,
          32'h00000000, 32'h00000000, 16'h0000, 1'b1, 17'h10000},
        // goal at opposite extremes, widest radius with bit 31 set in the data
        '{ROW_WRITE, gh_pkg::CFG_GOAL_X, 1'b0, 32'h7FFFFFFF, 32'h0,
          32'h0, 32'h0, 16'h0, 1'b0, 17'h0},
        '{ROW_WRITE, gh_pkg::CFG_GOAL_Y, 1'b0, 32'h80000000, 32'h0,
          32'h0, 32'h0, 16'h0, 1'b0, 17'h0},
        '{ROW_WRITE, gh_pkg::CFG_APPROACH, 1'b0, 32'hFFFFFFFF, 32'h0,
          32'h0, 32'h0, 16'h0, 1'b0, 17'h0},
        // write beyond the register list, dropped
        '{ROW_WRITE, REG_SPARE, 1'b0, 32'h55555555, 32'h0,
          32'h0, 32'h0, 16'h0, 1'b0, 17'h0},
        // longest vector the bearing chain can see
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h7FFFFFFF, 32'h80000000,
          32'h80000000, 32'h7FFFFFFF, 16'h0000, 1'b0, 17'h00000},
        // difference wider than 32 bits
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h80000000, 32'h80000000,
          32'h00000000, 32'h00000000, 16'h0000, 1'b1, 17'h10000},
        // inside widest radius, end on goal
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h3FFFFFFF, 32'h80000000,
          32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 1'b1, 17'h0FFFE},
        // distance equal to widest radius
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h00000000, 32'h80000000,
          32'h00000000, 32'h00000000, 16'h0000, 1'b1, 17'h10000},
        // zero radius scores nothing
        '{ROW_WRITE, gh_pkg::CFG_APPROACH, 1'b0, 32'h00000000, 32'h0,
          32'h0, 32'h0, 16'h0, 1'b0, 17'h0},
        '{ROW_ITEM, REG_SPARE, 1'b1, 32'h7FFFFFFF, 32'h80000000,
          32'h7FFFFFFF, 32'h80000000, 16'h0000, 1'b1, 17'h10000}
    };

    logic                                clk;
    logic                                rst_n       = 1'b0;
    logic                                cfg_write   = 1'b0;
    logic [gh_pkg::CFG_IDX_W-1:0]        cfg_index   = '0;
    logic [gh_pkg::COORD_W-1:0]          cfg_data    = '0;
    logic                                item_valid  = 1'b0;
    logic                                item_stall;
    logic                                has_points  = 1'b0;
    logic signed [gh_pkg::COORD_W-1:0]   start_x     = '0;
    logic signed [gh_pkg::COORD_W-1:0]   start_y     = '0;
    logic signed [gh_pkg::COORD_W-1:0]   end_x       = '0;
    logic signed [gh_pkg::COORD_W-1:0]   end_y       = '0;
    logic [gh_pkg::ANG_W-1:0]            end_heading = '0;
    logic                                cost_valid;
    logic                                cost_stall  = 1'b0;
    logic [gh_pkg::COST_W-1:0]           cost;

    // Register copies seen by the predictor
    logic signed [31:0] mirror_goal_x = '0;
    logic signed [31:0] mirror_goal_y = '0;
    logic [30:0]        mirror_radius = RADIUS_AT_RST;

    logic [16:0] pending_costs [$];
    preset_t     preset_costs [$];
    int          errors      = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          stall_hold  = 0;

    goal_heading_cost dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .has_points  (has_points),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .end_heading (end_heading),
        .cost_valid  (cost_valid),
        .cost_stall  (cost_stall),
        .cost        (cost)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Heading cost of one trajectory under the mirrored registers
    function automatic logic [16:0] predict_cost(input logic hp,
                                                 input logic signed [31:0] sx,
                                                 input logic signed [31:0] sy,
                                                 input logic signed [31:0] ex,
                                                 input logic signed [31:0] ey,
                                                 input logic [15:0] hd);
        longint          dx, dy, x, y, xs, ys;
        longint unsigned adx, ady, rad;
        logic [31:0]     ang;
        logic [15:0]     bear, diff;
        logic [16:0]     absd;
        int              i;
        if (!hp)
            return FULL_COST;
        dx  = longint'(sx) - longint'(mirror_goal_x);
        dy  = longint'(sy) - longint'(mirror_goal_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        rad = longint'(mirror_radius);
        if (adx >= 64'h8000_0000 || ady >= 64'h8000_0000)
            return FULL_COST;
        if (adx * adx + ady * ady >= rad * rad)
            return FULL_COST;

        // Bearing from end point to goal, vectoring rotation
        x = longint'(mirror_goal_x) - longint'(ex);
        y = longint'(mirror_goal_y) - longint'(ey);
        if (x == 0 && y == 0)
            bear = '0;
        else
        begin
            ang = '0;
            if (x < 0)
            begin
                x   = -x;
                y   = -y;
                ang = 32'h8000_0000;
            end
            for (i = 0; i < gh_pkg::CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x   = x + ys;
                    y   = y - xs;
                    ang = ang + TURN_ATAN[i];
                end
                else
                begin
                    x   = x - ys;
                    y   = y + xs;
                    ang = ang - TURN_ATAN[i];
                end
            end
            bear = 16'((ang + 32'h0000_8000) >> 16);
        end

        // Wrapped error magnitude, doubled into Q1.16
        diff = hd - bear;
        absd = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
        return {absd[15:0], 1'b0};
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_goal();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h7FFF_FFFF;
        if (r == 1)
            return 32'h8000_0000;
        if (r < 6)
            return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        return $urandom;
    endfunction

    task automatic record_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Present one item after a random gap and hold it until taken
    task automatic send_trajectory(input traj_t t, input logic fixed,
                                   input logic [16:0] value);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = next_gap();
            if ($urandom_range(0, 49) == 0)
                burst_left = $urandom_range(30, 100);
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        preset_costs.push_back('{fixed, value});
        item_valid  <= 1'b1;
        has_points  <= t.hp;
        start_x     <= t.sx;
        start_y     <= t.sy;
        end_x       <= t.ex;
        end_y       <= t.ey;
        end_heading <= t.hd;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic write_reg(input logic [gh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and let every outstanding cost come back
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_costs.size() != 0)
            @(posedge clk);
    endtask

    // Receiver back-pressure: stall and free stretches, some long and clear
    always @(posedge clk)
    begin
        if (!rst_n)
            cost_stall <= 1'b0;
        else if (stall_hold > 0)
            stall_hold--;
        else if ($urandom_range(0, 2) == 0)
        begin
            cost_stall <= 1'b1;
            stall_hold = next_gap();
        end
        else
        begin
            cost_stall <= 1'b0;
            stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : next_gap();
        end
    end

    // Mirror writes, predict accepted items, check accepted costs
    always @(posedge clk)
    begin : monitor
        preset_t     ps;
        logic [16:0] want;
        logic        busy;
        if (!rst_n)
        begin
            mirror_goal_x = '0;
            mirror_goal_y = '0;
            mirror_radius = RADIUS_AT_RST;
        end
        else
        begin
            busy = 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    gh_pkg::CFG_GOAL_X:   mirror_goal_x = cfg_data;
                    gh_pkg::CFG_GOAL_Y:   mirror_goal_y = cfg_data;
                    gh_pkg::CFG_APPROACH: mirror_radius = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                busy = 1'b1;
                ps   = preset_costs.pop_front();
                pending_costs.push_back(ps.fixed ? ps.value :
                    predict_cost(has_points, start_x, start_y, end_x, end_y, end_heading));
            end
            if (cost_valid && !cost_stall)
            begin
                busy = 1'b1;
                if (pending_costs.size() == 0)
                    record_failure($sformatf("unexpected cost %h, none pending", cost));
                else
                begin
                    want = pending_costs.pop_front();
                    if (cost !== want)
                        record_failure($sformatf("cost mismatch: expected %h, got %h",
                                                 want, cost));
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no item or cost moving
    initial
    begin
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("** goal_heading_cost: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t    row;
        traj_t       t;
        logic [31:0] cur_gx, cur_gy;
        logic [30:0] cur_rad;
        int unsigned span;
        int          sent, n, r;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(row.reg_index, row.sx);
            end
            else
                send_trajectory('{row.hp, row.sx, row.sy, row.ex, row.ey, row.hd},
                                row.fixed, row.cost);
        end

        // Random phases, each under a fresh register setting
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            cur_gx = pick_goal();
            cur_gy = pick_goal();
            r = $urandom_range(0, 9);
            if (r == 0)
                cur_rad = '0;
            else if (r == 1)
                cur_rad = 31'h7FFF_FFFF;
            else if (r < 6)
                cur_rad = 31'($urandom_range(1, 32'h0010_0000));
            else
                cur_rad = 31'($urandom_range(1, 32'h7FFF_FFFF));
            write_reg(gh_pkg::CFG_GOAL_X, cur_gx);
            write_reg(gh_pkg::CFG_GOAL_Y, cur_gy);
            write_reg(gh_pkg::CFG_APPROACH, {1'($urandom_range(0, 1)), cur_rad});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, $urandom);

            n = $urandom_range(30, 90);
            repeat (n)
            begin
                r    = $urandom_range(0, 99);
                t.hp = (r >= 4);
                t.sx = $urandom;
                t.sy = $urandom;
                t.ex = $urandom;
                t.ey = $urandom;
                t.hd = 16'($urandom);
                // most items start inside the radius so the bearing is scored
                if (r >= 15)
                begin
                    span = cur_rad >> 1;
                    t.sx = cur_gx + ($urandom_range(0, 2 * span) - span);
                    t.sy = cur_gy + ($urandom_range(0, 2 * span) - span);
                    r    = $urandom_range(0, 9);
                    if (r == 0)
                    begin
                        t.ex = cur_gx;
                        t.ey = cur_gy;
                    end
                    else if (r < 4)
                    begin
                        t.ex = cur_gx + ($urandom_range(0, 511) - 256);
                        t.ey = cur_gy + ($urandom_range(0, 511) - 256);
                    end
                end
                send_trajectory(t, 1'b0, '0);
                sent++;
            end
        end

        // Drain and report
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** goal_heading_cost: PASSED **");
        else
            $display("** goal_heading_cost: FAILED **");
        $finish;
    end

endmodule
